[rtl/tli_pkg.sv]
// Shared types and constants of the table linear interpolator.
package tli_pkg;

  localparam int VALUE_W = 16;
  localparam int INDEX_W = 6;
  localparam int LEN_W   = 7;
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int CNT_W   = $clog2(PROD_W + 1);
  localparam int ENTRY_W = 2 * VALUE_W;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REGION_INTERP = 2'd0;
  localparam logic [1:0] REGION_BELOW  = 2'd1;
  localparam logic [1:0] REGION_EXACT  = 2'd2;
  localparam logic [1:0] REGION_BEYOND = 2'd3;

  typedef logic [VALUE_W-1:0] val_t;

  typedef struct packed {
    logic               op;
    logic [INDEX_W-1:0] entry_index;
    val_t               entry_x;
    val_t               entry_y;
    val_t               query_x;
  } in_item_t;

  typedef struct packed {
    val_t       result_y;
    logic [1:0] region;
  } out_item_t;

  typedef struct packed {
    val_t x;
    val_t y;
  } entry_t;

  // Request to the multiply and divide unit: mag = dy * dq / dx.
  typedef struct packed {
    logic start;
    val_t dy;
    val_t dq;
    val_t dx;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] mag;
  } div_rsp_t;

endpackage

[rtl/table_linear_interpolator.sv]
// Top level of the piecewise linear interpolation lookup table.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   in_data   (in_item_t: load or query)
//   out_     output     out_valid / out_ready out_data  (out_item_t: result_y, region)
//   cfg_     input      cfg_valid / cfg_ready cfg_data  (table_length, 7 bits)
//
// After a load the input stays ready for the next item. A query either settles on an
// entry read without interpolation or interpolates: the scan reads one breakpoint a
// cycle from the table memory, then a 16x16 multiply and a 32-step restoring divide
// in the divide unit set the figure.
// Reset is synchronous and active low; the table contents are not cleared.
// Loads are still taken while a result waits on a stalled out_ready; a query
// finishes its work and then holds until the output register is free.
module table_linear_interpolator
  import tli_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam val_t VAL_MAX = '1;

  // Control state.
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] last_idx_r;
  logic          out_valid_r;

  // Payload registers.
  val_t      q_r;
  entry_t    prev_r;
  val_t      ya_r;
  logic      neg_r;
  val_t      res_r;
  logic [1:0] region_r;
  out_item_t out_r;

  // Table memory and divide unit.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t        cur;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  logic          accept, is_query, is_load, out_free;
  logic          set_res;
  val_t          res_nxt;
  logic [1:0]    region_nxt;
  logic          capture_seg;

  // Segment arithmetic on the pair (prev_r, cur).
  logic ndx, ndy, ndq;
  val_t dx, dy, dq;
  logic [PROD_W:0] sat_sum;
  val_t sat_val;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign is_query  = accept && (in_data.op == OP_QUERY);
  assign is_load   = accept && (in_data.op == OP_LOAD);
  assign out_free  = !out_valid_r || out_ready;

  // A load whose index is not below TABLE_DEPTH is dropped.
  assign ram_we    = is_load && (32'(in_data.entry_index) < TABLE_DEPTH);
  assign ram_waddr = AW'(in_data.entry_index);
  // Reads stream one entry ahead of the entry being examined.
  assign ram_re    = is_query || (state_r == S_SCAN);
  assign ram_raddr = is_query ? '0 : AW'(idx_r + AW'(1));

  tli_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_data.entry_x, in_data.entry_y}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur = entry_t'(ram_rdata);

  assign ndx = cur.x < prev_r.x;
  assign ndy = cur.y < prev_r.y;
  assign ndq = q_r < prev_r.x;
  assign dx  = ndx ? val_t'(prev_r.x - cur.x) : val_t'(cur.x - prev_r.x);
  assign dy  = ndy ? val_t'(prev_r.y - cur.y) : val_t'(cur.y - prev_r.y);
  assign dq  = ndq ? val_t'(prev_r.x - q_r)   : val_t'(q_r - prev_r.x);

  assign div_req.start = capture_seg && (dx != '0);
  assign div_req.dy    = dy;
  assign div_req.dq    = dq;
  assign div_req.dx    = dx;

  tli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // The quotient is applied to the y of the lower breakpoint and the sum saturates to the value range.
  always_comb begin
    sat_sum = '0;
    if (neg_r) begin
      if (div_rsp.mag > PROD_W'(ya_r)) begin
        sat_val = '0;
      end else begin
        sat_val = val_t'(ya_r - val_t'(div_rsp.mag));
      end
    end else begin
      sat_sum = (PROD_W + 1)'(ya_r) + (PROD_W + 1)'(div_rsp.mag);
      if (sat_sum > (PROD_W + 1)'(VAL_MAX)) begin
        sat_val = VAL_MAX;
      end else begin
        sat_val = val_t'(sat_sum);
      end
    end
  end

  // Sequencer: scan the breakpoints, then divide if the query falls inside a segment of nonzero width.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    set_res     = 1'b0;
    res_nxt     = res_r;
    region_nxt  = region_r;
    capture_seg = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (is_query) begin
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r == '0) begin
          if (q_r < cur.x) begin
            set_res    = 1'b1;
            res_nxt    = '0;
            region_nxt = REGION_BELOW;
            state_nxt  = S_FIN;
          end else if (last_idx_r == '0) begin
            set_res    = 1'b1;
            res_nxt    = cur.y;
            region_nxt = REGION_BEYOND;
            state_nxt  = S_FIN;
          end else begin
            idx_nxt = AW'(idx_r + AW'(1));
          end
        end else if (q_r > cur.x) begin
          if (idx_r == last_idx_r) begin
            set_res    = 1'b1;
            res_nxt    = cur.y;
            region_nxt = REGION_BEYOND;
            state_nxt  = S_FIN;
          end else begin
            idx_nxt = AW'(idx_r + AW'(1));
          end
        end else if (q_r == prev_r.x) begin
          set_res    = 1'b1;
          res_nxt    = prev_r.y;
          region_nxt = REGION_EXACT;
          state_nxt  = S_FIN;
        end else begin
          capture_seg = 1'b1;
          region_nxt  = REGION_INTERP;
          if (dx == '0) begin
            // A zero-width segment gives the y of the lower breakpoint.
            set_res   = 1'b1;
            res_nxt   = prev_r.y;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          set_res   = 1'b1;
          res_nxt   = sat_val;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      last_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      // The length is clamped to 1 .. TABLE_DEPTH and kept as the last index.
      if (cfg_valid && cfg_ready) begin
        if (cfg_data == '0) begin
          last_idx_r <= '0;
        end else if (32'(cfg_data) > TABLE_DEPTH) begin
          last_idx_r <= AW'(TABLE_DEPTH - 1);
        end else begin
          last_idx_r <= AW'(32'(cfg_data) - 32'd1);
        end
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_query) begin
      q_r <= in_data.query_x;
    end
    // Every entry examined without settling becomes the lower breakpoint.
    if (state_r == S_SCAN) begin
      prev_r <= cur;
    end
    if (capture_seg) begin
      ya_r  <= prev_r.y;
      neg_r <= ndx ^ ndy ^ ndq;
    end
    if (set_res) begin
      res_r <= res_nxt;
    end
    if (set_res || capture_seg) begin
      region_r <= region_nxt;
    end
    if (state_r == S_FIN && out_free) begin
      out_r.result_y <= res_r;
      out_r.region   <= region_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // A query closes the input until its result has been moved into the output register.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.op == OP_QUERY) |=> !in_ready)
    else $error("input still ready after a query transfer");

  // The divide unit reports completion only while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divide completion outside the divide state");

  // The scan never runs past the last entry in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= last_idx_r))
    else $error("scan index beyond the table length");

  // A query below the first breakpoint always gives zero.
  a_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.region == REGION_BELOW) |-> (out_data.result_y == '0))
    else $error("non-zero result below the first breakpoint");
`endif

endmodule

[rtl/tli_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/tli_div.sv]
// Multiply then restoring bit-serial divide: mag = dy * dq / dx, truncated.
module tli_div
  import tli_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_DIV  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  val_t              dy_r, dq_r, dx_r;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  val_t              rem_r, rem_nxt;

  logic [VALUE_W:0]  rem_sh;
  logic              ge;

  assign rem_sh = {rem_r, quo_r[PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, dx_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          state_nxt = D_MUL;
        end
      end
      D_MUL: begin
        quo_nxt   = PROD_W'(dy_r * dq_r);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(PROD_W);
        state_nxt = D_DIV;
      end
      D_DIV: begin
        quo_nxt = {quo_r[PROD_W-2:0], ge};
        rem_nxt = ge ? VALUE_W'(rem_sh - {1'b0, dx_r}) : VALUE_W'(rem_sh);
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == D_IDLE && req.start) begin
      dy_r <= req.dy;
      dq_r <= req.dq;
      dx_r <= req.dx;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.mag  = quo_r;

endmodule

[verif/tli_result_checker.sv]
`timescale 1ns / 100ps
// Checker that predicts and compares every lookup result of the table linear interpolator.
module tli_result_checker
  import tli_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data,
  output int               mismatches,
  output int               lookups_owed
);

  val_t             bp_x [DEPTH];
  val_t             bp_y [DEPTH];
  logic [LEN_W-1:0] length_reg;
  out_item_t        owed_results [$];
  out_item_t        oldest;

  task automatic report(input string msg);
    $display("%0t ns: mismatch, %s", $realtime, msg);
    mismatches++;
  endtask

  // Linear step from the lower breakpoint, with the sign of each difference
  // tracked apart and the sum clamped to the value range.
  function automatic val_t interp_segment(input val_t xa, input val_t xb, input val_t ya,
                                          input val_t yb, input val_t qx);
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] dq;
    logic [63:0] mag;
    logic [63:0] sum;
    logic        flip;
    dx   = (xb >= xa) ? 64'(xb - xa) : 64'(xa - xb);
    dy   = (yb >= ya) ? 64'(yb - ya) : 64'(ya - yb);
    dq   = (qx >= xa) ? 64'(qx - xa) : 64'(xa - qx);
    flip = (xb < xa) ^ (yb < ya) ^ (qx < xa);
    if (dx == 0) begin
      return ya;
    end
    mag = (dy * dq) / dx;
    if (flip) begin
      sum = (mag > ya) ? 64'd0 : ya - mag;
    end else begin
      sum = (mag > 64'hFFFF - ya) ? 64'hFFFF : ya + mag;
    end
    return sum[VALUE_W-1:0];
  endfunction

  function automatic out_item_t predict_lookup(input val_t qx);
    out_item_t res;
    int        used;
    bit        found;
    used  = (length_reg == 0) ? 1 : ((length_reg > DEPTH) ? DEPTH : int'(length_reg));
    found = 1'b0;
    if (qx < bp_x[0]) begin
      res.result_y = '0;
      res.region   = REGION_BELOW;
    end else begin
      res.result_y = bp_y[used-1];
      res.region   = REGION_BEYOND;
      for (int i = 1; i < used; i++) begin
        if (!found && qx <= bp_x[i]) begin
          found = 1'b1;
          if (qx == bp_x[i-1]) begin
            res.result_y = bp_y[i-1];
            res.region   = REGION_EXACT;
          end else begin
            res.result_y = interp_segment(bp_x[i-1], bp_x[i], bp_y[i-1], bp_y[i], qx);
            res.region   = REGION_INTERP;
          end
        end
      end
    end
    return res;
  endfunction

  // The output side is looked at first, so that a result can never be matched
  // against a lookup accepted at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      length_reg = LEN_W'(1);
      owed_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report($sformatf("result_y %0d region %0d with no lookup outstanding",
                           out_data.result_y, out_data.region));
        end else begin
          oldest = owed_results.pop_front();
          if (out_data.result_y !== oldest.result_y) begin
            report($sformatf("result_y %0d, predicted %0d", out_data.result_y,
                             oldest.result_y));
          end
          if (out_data.region !== oldest.region) begin
            report($sformatf("region %0d, predicted %0d", out_data.region, oldest.region));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        length_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_LOAD) begin
          bp_x[in_data.entry_index] = in_data.entry_x;
          bp_y[in_data.entry_index] = in_data.entry_y;
        end else begin
          owed_results.push_back(predict_lookup(in_data.query_x));
        end
      end
    end
    lookups_owed <= owed_results.size();
  end

endmodule

[verif/table_linear_interpolator_test.sv]
`timescale 1ns / 100ps
// Top of the table linear interpolator regression: clock, reset, stimulus and verdict.
module table_linear_interpolator_test
  import tli_pkg::*;
();

  localparam int          DEPTH         = 64;
  localparam int          RANDOM_ITEMS  = 1600;
  // A query that scans the whole table and then interpolates finishes well within
  // this, so it comfortably covers any work still in flight.
  localparam int          SETTLE_CYCLES = 128;
  // Far beyond the slowest legal run: every item waiting out the longest gap
  // on both sides plus a full scan and divide.
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data  = '0;

  int               mismatches;
  int               lookups_owed;

  // Copy of what has been loaded, used only to aim queries at the breakpoints.
  val_t             shadow_x [DEPTH];
  int               items_sent;
  bit               steady_in;

  table_linear_interpolator #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  tli_result_checker #(
    .DEPTH(DEPTH)
  ) lookup_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .lookups_owed(lookups_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(40, 120);
  endfunction

  function automatic int effective_length(input logic [LEN_W-1:0] code);
    if (code == 0) begin
      return 1;
    end
    return (code > DEPTH) ? DEPTH : int'(code);
  endfunction

  // Query abscissa for a table of n entries in use: often a breakpoint or
  // one step either side of it, sometimes below the table or at the ends of
  // the range, otherwise anywhere.
  function automatic val_t pick_query(input int n);
    int unsigned r;
    int unsigned j;
    r = $urandom_range(0, 99);
    j = $urandom_range(0, n - 1);
    if (r < 30) begin
      return shadow_x[j];
    end else if (r < 40) begin
      return shadow_x[j] + 1'b1;
    end else if (r < 50) begin
      return shadow_x[j] - 1'b1;
    end else if (r < 58) begin
      return (shadow_x[0] == 0) ? val_t'(0) : val_t'($urandom_range(0, shadow_x[0] - 1));
    end else if (r < 64) begin
      return '0;
    end else if (r < 70) begin
      return '1;
    end else if (r < 90) begin
      return val_t'($urandom_range(shadow_x[0], shadow_x[n-1]));
    end
    return val_t'($urandom);
  endfunction

  // One transfer on the input channel, preceded by a random gap unless this
  // phase runs without idling. Valid is only lowered when a gap is due.
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = steady_in ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.op == OP_LOAD) begin
      shadow_x[item.entry_index] = item.entry_x;
    end
    items_sent++;
  endtask

  // The fields that a load does not use carry random bits all the same.
  task automatic load_entry(input int idx, input val_t x, input val_t y);
    in_item_t item;
    item.op          = OP_LOAD;
    item.entry_index = INDEX_W'(idx);
    item.entry_x     = x;
    item.entry_y     = y;
    item.query_x     = val_t'($urandom);
    send_item(item);
  endtask

  task automatic ask(input val_t qx);
    in_item_t item;
    item.op          = OP_QUERY;
    item.entry_index = INDEX_W'($urandom);
    item.entry_x     = val_t'($urandom);
    item.entry_y     = val_t'($urandom);
    item.query_x     = qx;
    send_item(item);
  endtask

  // Holds the input back until every predicted result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (lookups_owed != 0);
  endtask

  // The length register is only written once the block has gone quiet: a
  // trailing load leaves no result to wait for, hence the extra settling time.
  task automatic write_length(input logic [LEN_W-1:0] code);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= code;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The receiving side runs in bursts of readiness separated by stalls, with
  // the occasional long stretch where it never stalls at all.
  initial begin : ready_driver
    int unsigned run;
    int unsigned stall;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = gap_len();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0] len_code;
    int               used;
    int               n_queries;
    int               step_max;
    int               acc;
    int               phase;
    bit               ascending;
    val_t             new_x [DEPTH];
    val_t             new_y [DEPTH];

    items_sent = 0;
    steady_in  = 1'b0;
    phase      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The length register comes out of reset at one entry, so
    // a single breakpoint already makes a complete table: below it, on it and
    // at the top of the range.
    load_entry(0, 16'd1000, 16'd500);
    ask(16'd0);
    ask(16'd999);
    ask(16'd1000);
    ask(16'hFFFF);

    // Four entries with a repeated abscissa at the start, a rising and a
    // falling segment, both extremes of the ordinate and the top of the abscissa.
    write_length(LEN_W'(4));
    load_entry(0, 16'd100, 16'd10);
    load_entry(1, 16'd100, 16'd200);
    load_entry(2, 16'd1000, 16'hFFFF);
    load_entry(3, 16'hFFFF, 16'd0);
    ask(16'd99);
    ask(16'd100);
    ask(16'd550);
    ask(16'd1000);
    ask(16'd30000);
    ask(16'hFFFF);

    // A length of zero must behave as a one-entry table.
    write_length(LEN_W'(0));
    ask(16'd100);
    ask(16'd20);

    // Three entries whose abscissae do not ascend, then one that descends in
    // ordinate, so that the second breakpoint lies beyond the query.
    write_length(LEN_W'(3));
    load_entry(2, 16'd50, 16'd7);
    ask(16'd200);
    ask(16'd60);
    load_entry(1, 16'd300, 16'd0);
    ask(16'd200);

    // Random part: each phase picks a length, loads a complete table for it
    // and then queries it, with the odd stray load mixed in. Most tables are
    // ascending, some are not. The first two phases cover the full table and
    // a length beyond the store.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        len_code = LEN_W'(DEPTH);
      end else if (phase == 1) begin
        len_code = '1;
      end else begin
        case ($urandom_range(0, 19))
          0:       len_code = '0;
          1:       len_code = LEN_W'(DEPTH);
          2:       len_code = LEN_W'($urandom_range(DEPTH + 1, 127));
          3, 4, 5: len_code = LEN_W'($urandom_range(9, DEPTH - 1));
          default: len_code = LEN_W'($urandom_range(1, 8));
        endcase
      end
      used      = effective_length(len_code);
      steady_in = ($urandom_range(0, 3) == 0);
      write_length(len_code);

      ascending = ($urandom_range(0, 6) != 0);
      step_max  = 2 * 65535 / used;
      acc       = $urandom_range(0, 4000);
      for (int k = 0; k < used; k++) begin
        if (ascending) begin
          new_x[k] = (acc > 65535) ? 16'hFFFF : val_t'(acc);
          // Now and then a step of zero, giving a repeated abscissa.
          acc += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, step_max);
        end else begin
          new_x[k] = val_t'($urandom);
        end
        case ($urandom_range(0, 7))
          0:       new_y[k] = '0;
          1:       new_y[k] = '1;
          default: new_y[k] = val_t'($urandom);
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        for (int k = 0; k < used; k++) load_entry(k, new_x[k], new_y[k]);
      end else begin
        for (int k = used - 1; k >= 0; k--) load_entry(k, new_x[k], new_y[k]);
      end

      n_queries = $urandom_range(3, 40);
      for (int k = 0; k < n_queries; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          load_entry($urandom_range(0, DEPTH - 1), val_t'($urandom), val_t'($urandom));
        end
        // Occasionally hold the sender back mid-phase until the output side
        // has caught up completely.
        if (k == n_queries / 2 && $urandom_range(0, 5) == 0) begin
          drain_results();
        end
        ask(pick_query(used));
      end
      phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tli_pkg.sv
rtl/tli_ram.sv
rtl/tli_div.sv
rtl/table_linear_interpolator.sv
verif/tli_result_checker.sv
verif/table_linear_interpolator_test.sv
